>>> hw/rtl/b64l_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64l_pkg;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int PAddrW = 3;
  localparam int PDataW = 32;
  localparam logic RegDirection = 1'b0;

  // Direction codes.
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // Depth of the queue between front and back (a power of two).
  localparam int QDepth = 2;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  // One queue entry holds the results that one input item causes.
  typedef struct packed {
    logic [7:0] byte0;
    logic       last0;
    logic       has1;
    logic [7:0] byte1;
    logic       last1;
  } b64l_entry_t;

  // Push request from the front to the queue.
  typedef struct packed {
    logic        valid;
    b64l_entry_t entry;
  } b64l_push_t;

  // Map a 6-bit digit to its alphabet character.
  function automatic logic [7:0] digit_to_char(input logic [5:0] d);
    logic [7:0] dw;
    dw = {2'b00, d};
    if (d == 6'd0) begin
      return 8'd43;
    end else if (d < 6'd12) begin
      return dw + 8'd46;
    end else if (d < 6'd38) begin
      return dw + 8'd53;
    end else begin
      return dw + 8'd59;
    end
  endfunction

  // Map a character back to a digit; invalid characters wrap modulo 256.
  function automatic logic [7:0] char_to_digit(input logic [7:0] c);
    if (c == 8'd43) begin
      return 8'd0;
    end else if (c < 8'd58) begin
      return c - 8'd46;
    end else if (c < 8'd91) begin
      return c - 8'd53;
    end else begin
      return c - 8'd59;
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/b64l_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one byte or character per transfer.
interface b64l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// Output channel: one character or byte per transfer.
interface b64l_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/base64_lsb_codec.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming base64-style codec, alphabet '+', '/', '0'-'9', 'A'-'Z', 'a'-'z', bits packed least
// significant first. The direction register (byte address 0, bit 0) selects encoding of bytes
// to characters (0) or decoding of characters to bytes (1); any write to it restarts the group.
// Write it only while the block is idle. The front stage takes one input transfer per cycle
// whenever the two-entry result queue has room; the single output register then sends one
// result per cycle while the port is ready, so an item with two results holds the port for both
// in turn. Sustained, decoding runs at one character per cycle; encoding is slower, as the
// third byte of a group gives two characters. Results go via the queue to the output register.
module base64_lsb_codec
  import b64l_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  b64l_in_if.sink            in_stream,
  b64l_out_if.source         out_stream,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [PAddrW-1:0]  paddr,
  input  wire  [PDataW-1:0]  pwdata,
  output logic [PDataW-1:0]  prdata,
  output logic               pready
);

  logic        direction;
  logic        cfg_clear;
  b64l_push_t  push;
  b64l_entry_t head;
  logic        empty;
  logic        full;
  logic        pop;

  assign pready = 1'b1;
  assign cfg_clear = psel && penable && pwrite && (paddr[2] == RegDirection);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DirEncode;
    end else if (cfg_clear) begin
      direction <= pwdata[0];
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegDirection) begin
      prdata = {{(PDataW-1){1'b0}}, direction};
    end
  end

  b64l_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .direction  (direction),
    .cfg_clear  (cfg_clear),
    .queue_full (full),
    .push       (push)
  );

  b64l_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  b64l_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule

`default_nettype wire

>>> hw/rtl/b64l_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64l_front
  import b64l_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  b64l_in_if.sink    in_stream,
  input  wire        direction,
  input  wire        cfg_clear,
  input  wire        queue_full,
  output b64l_push_t push
);

  logic [1:0] pos;
  logic [1:0] pos_next;
  logic [7:0] pend;
  logic [7:0] pend_next;
  logic [7:0] digit;
  logic [7:0] b;
  logic       last;
  logic       accept;

  assign in_stream.ready = !queue_full;
  assign accept = in_stream.valid && !queue_full;
  assign b = in_stream.in_byte;
  assign last = in_stream.in_last;
  assign digit = char_to_digit(b);

  // Work out the results of the current item and the next group state.
  always_comb begin
    push.entry = '0;
    pos_next = pos;
    pend_next = pend;
    if (direction == DirEncode) begin
      push.entry.has1 = last;
      push.entry.last1 = last;
      unique case (pos)
        2'd0: begin
          push.entry.byte0 = digit_to_char(b[5:0]);
          push.entry.byte1 = digit_to_char({4'b0000, b[7:6]});
          pend_next = {6'b000000, b[7:6]};
          pos_next = 2'd1;
        end
        2'd1: begin
          push.entry.byte0 = digit_to_char({b[3:0], pend[1:0]});
          push.entry.byte1 = digit_to_char({2'b00, b[7:4]});
          pend_next = {4'b0000, b[7:4]};
          pos_next = 2'd2;
        end
        default: begin
          push.entry.byte0 = digit_to_char({b[1:0], pend[3:0]});
          push.entry.byte1 = digit_to_char(b[7:2]);
          push.entry.has1 = 1'b1;
          pend_next = '0;
          pos_next = 2'd0;
        end
      endcase
      push.valid = accept;
    end else begin
      push.entry.last0 = last;
      unique case (pos)
        2'd0: begin
          pend_next = digit;
          pos_next = 2'd1;
        end
        2'd1: begin
          push.entry.byte0 = pend | {digit[1:0], 6'b000000};
          pend_next = {4'b0000, digit[5:2]};
          pos_next = 2'd2;
        end
        2'd2: begin
          push.entry.byte0 = pend | {digit[3:0], 4'b0000};
          pend_next = {6'b000000, digit[5:4]};
          pos_next = 2'd3;
        end
        default: begin
          push.entry.byte0 = pend | {digit[5:0], 2'b00};
          pend_next = '0;
          pos_next = 2'd0;
        end
      endcase
      // The first character of a group gives no result.
      push.valid = accept && (pos != 2'd0);
    end
    if (last) begin
      pos_next = 2'd0;
      pend_next = '0;
    end
  end

  // Group state; a direction write abandons a partial group.
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      pos <= 2'd0;
      pend <= '0;
    end else if (accept) begin
      pos <= pos_next;
      pend <= pend_next;
    end
  end

  // An encoding group never reaches a fourth position.
  a_enc_pos: assert property (@(posedge clk) disable iff (rst)
    (direction == DirEncode) |-> (pos != 2'd3))
    else $error("encode group position out of range");

  // Pending bits in encode mode never exceed four bits.
  a_enc_pend: assert property (@(posedge clk) disable iff (rst)
    (direction == DirEncode) |-> (pend[7:4] == 4'b0000))
    else $error("encode pending bits too wide");

endmodule

`default_nettype wire

>>> hw/rtl/b64l_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module b64l_queue
  import b64l_pkg::*;
(
  input  wire             clk,
  input  wire             rst,
  input  wire b64l_push_t push,
  input  wire             pop,
  output b64l_entry_t     head,
  output logic            empty,
  output logic            full
);

  b64l_entry_t            slots [QDepth];
  logic        [QPtrW-1:0] wr_ptr;
  logic        [QPtrW-1:0] rd_ptr;
  logic        [QCntW-1:0] count;
  logic                    do_push;
  logic                    do_pop;

  assign empty = (count == '0);
  assign full = (count == QCntW'(QDepth));
  assign head = slots[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop = pop && !empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> hw/rtl/b64l_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64l_back
  import b64l_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire b64l_entry_t head,
  input  wire              empty,
  output logic             pop,
  b64l_out_if.source       out_stream
);

  logic [7:0]  held_byte;
  logic        held_last;
  logic        second_pend;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        load;

  assign out_stream.valid = out_valid;
  assign out_stream.out_byte = out_byte;
  assign out_stream.out_last = out_last;

  // The output register takes a new result when empty or being drained.
  assign load = !out_valid || out_stream.ready;
  assign pop = load && !second_pend && !empty;

  // Control: output valid and the pending second result of an entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second_pend <= 1'b0;
    end else if (load) begin
      out_valid <= second_pend || !empty;
      if (second_pend) begin
        second_pend <= 1'b0;
      end else if (!empty) begin
        second_pend <= head.has1;
      end
    end
  end

  // Payload: first result from the queue head, second from the held copy.
  always_ff @(posedge clk) begin
    if (load) begin
      if (second_pend) begin
        out_byte <= held_byte;
        out_last <= held_last;
      end else if (!empty) begin
        out_byte <= head.byte0;
        out_last <= head.last0;
        held_byte <= head.byte1;
        held_last <= head.last1;
      end
    end
  end

  // A second result only waits behind a first one still on the port.
  a_second_behind_first: assert property (@(posedge clk) disable iff (rst)
    second_pend |-> out_valid)
    else $error("second result pending without a first");

endmodule

`default_nettype wire
